>>> src/rebd_pkg.sv
// Shared types, constants and the full-step phase table of the rotary encoder decoder.
`default_nettype none

package rebd_pkg;

  localparam int unsigned HistoryLen = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned TimerWidth = 16;

  localparam logic [CfgWidth-1:0] ShortPressReset = 16'd200;
  localparam logic [CfgWidth-1:0] LongPressReset  = 16'd50000;
  localparam logic [CfgWidth-1:0] TimerLimitReset = 16'd65000;

  typedef enum logic [1:0] {
    CFG_SHORT_PRESS = 2'd0,
    CFG_LONG_PRESS  = 2'd1,
    CFG_TIMER_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_CW   = 2'd1,
    TURN_CCW  = 2'd2
  } turn_dir_e;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_SHORT = 2'd1,
    PRESS_LONG  = 2'd2
  } press_event_e;

  typedef enum logic [2:0] {
    ST_REST     = 3'd0,
    ST_CW_LAST  = 3'd1,
    ST_CW_FIRST = 3'd2,
    ST_CW_MID   = 3'd3,
    ST_CC_FIRST = 3'd4,
    ST_CC_LAST  = 3'd5,
    ST_CC_MID   = 3'd6
  } phase_state_e;

  typedef struct packed {
    turn_dir_e    turn;
    phase_state_e next;
  } step_t;

  typedef struct packed {
    turn_dir_e    turn_dir;
    press_event_e press_event;
    logic         turn_while_held;
  } result_t;

  function automatic step_t step_lookup(input phase_state_e state, input logic [1:0] phases);
    step_t s;
    s.turn = TURN_NONE;
    s.next = ST_REST;
    unique case (state)
      ST_CW_LAST: begin
        case (phases)
          2'd0:    s.next = ST_CW_MID;
          2'd1:    s.next = ST_REST;
          2'd2:    s.next = ST_CW_LAST;
          default: begin
            s.next = ST_REST;
            s.turn = TURN_CW;
          end
        endcase
      end
      ST_CW_FIRST: begin
        case (phases)
          2'd0:    s.next = ST_CW_MID;
          2'd1:    s.next = ST_CW_FIRST;
          default: s.next = ST_REST;
        endcase
      end
      ST_CW_MID: begin
        case (phases)
          2'd0:    s.next = ST_CW_MID;
          2'd1:    s.next = ST_CW_FIRST;
          2'd2:    s.next = ST_CW_LAST;
          default: s.next = ST_REST;
        endcase
      end
      ST_CC_FIRST: begin
        case (phases)
          2'd0:    s.next = ST_CC_MID;
          2'd2:    s.next = ST_CC_FIRST;
          default: s.next = ST_REST;
        endcase
      end
      ST_CC_LAST: begin
        case (phases)
          2'd0:    s.next = ST_CC_MID;
          2'd1:    s.next = ST_CC_LAST;
          2'd2:    s.next = ST_REST;
          default: begin
            s.next = ST_REST;
            s.turn = TURN_CCW;
          end
        endcase
      end
      ST_CC_MID: begin
        case (phases)
          2'd0:    s.next = ST_CC_MID;
          2'd1:    s.next = ST_CC_LAST;
          2'd2:    s.next = ST_CC_FIRST;
          default: s.next = ST_REST;
        endcase
      end
      default: begin
        // rest row; the unused state code behaves as rest
        case (phases)
          2'd1:    s.next = ST_CW_FIRST;
          2'd2:    s.next = ST_CC_FIRST;
          default: s.next = ST_REST;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/rotary_encoder_button_decoder_unit.sv
// Top level of the rotary encoder and push-button decoder.
`default_nettype none

// Rotary encoder and push-button decoder. Each item is one sample of the two
// quadrature pins (phase_levels_i, bit 0 phase one) and the raw active-low
// button pin (switch_level_i), and gives exactly one result item: a clockwise
// or counter-clockwise step, a short or long press reported on release, and a
// flag when the knob turns while the button is held (which cancels the press).
// The button counts as pressed after sixteen consecutive pressed samples.
// Throughput is one item per clock cycle while the skid entry is free, and the
// result is registered. The whole update is one pass of logic from the input
// pins into the state and result registers, and a second result register
// behind the output keeps in_ready_o high while one result waits on out_ready_i.
// The user must write the registers (short press, long press, timer limit)
// through the cfg port only while the block is idle; the block does not enforce it.
module rotary_encoder_button_decoder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [rebd_pkg::CfgWidth-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    phase_levels_i,
  input  wire logic                          switch_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         turn_dir_o,
  output logic [1:0]                         press_event_o,
  output logic                               turn_while_held_o
);
  import rebd_pkg::*;

  // configuration registers
  logic [CfgWidth-1:0] short_press_q, long_press_q, timer_limit_q;

  // decoder state
  phase_state_e            phase_state_q, phase_state_d;
  logic [HistoryLen-1:0]   history_q, history_d;
  logic                    debounced_q, debounced_d;
  logic [TimerWidth-1:0]   timer_q, timer_d;

  // output stage: result register plus a skid entry behind it
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, result;

  logic  in_accept, out_free;
  logic  held;
  step_t step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_press_q <= ShortPressReset;
      long_press_q  <= LongPressReset;
      timer_limit_q <= TimerLimitReset;
    end else if (cfg_valid_i) begin
      // indexes beyond the list are dropped
      case (cfg_idx_e'(cfg_index_i))
        CFG_SHORT_PRESS: short_press_q <= cfg_data_i;
        CFG_LONG_PRESS:  long_press_q  <= cfg_data_i;
        CFG_TIMER_LIMIT: timer_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One pass over the item: shift in the button sample, walk the phase
  // table, then resolve press edges, turns while held and the timer.
  always_comb begin
    history_d     = {history_q[HistoryLen-2:0], ~switch_level_i};
    held          = &history_d;
    step          = step_lookup(phase_state_q, phase_levels_i);
    phase_state_d = step.next;
    debounced_d   = debounced_q;
    timer_d       = timer_q;

    result.turn_dir        = step.turn;
    result.press_event     = PRESS_NONE;
    result.turn_while_held = 1'b0;

    if (held != debounced_q) begin
      debounced_d = held;
      if (held) begin
        // press edge: start timing, any step is reported without the flag
        timer_d = TimerWidth'(1);
      end else begin
        // release edge: long test first, a press event replaces the step
        if (timer_q > long_press_q) begin
          result.press_event = PRESS_LONG;
          result.turn_dir    = TURN_NONE;
        end else if (timer_q > short_press_q) begin
          result.press_event = PRESS_SHORT;
          result.turn_dir    = TURN_NONE;
        end
        timer_d = '0;
      end
    end else if (held) begin
      if (step.turn != TURN_NONE) begin
        // turn while held: flag it and cancel the pending press
        result.turn_while_held = 1'b1;
        timer_d                = '0;
      end else if (timer_q != '0 && timer_q < timer_limit_q) begin
        timer_d = timer_q + TimerWidth'(1);
      end
    end
  end

  // Hold new items off only while the skid entry is occupied.
  assign in_ready_o = ~skid_valid_q;
  assign in_accept  = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_state_q <= ST_REST;
      history_q     <= '0;
      debounced_q   <= 1'b0;
      timer_q       <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_state_q <= phase_state_d;
        history_q     <= history_d;
        debounced_q   <= debounced_d;
        timer_q       <= timer_d;
      end
      if (out_free) begin
        // advance: skid first, else the fresh result
        out_valid_q  <= skid_valid_q | in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign turn_dir_o        = out_q.turn_dir;
  assign press_event_o     = out_q.press_event;
  assign turn_while_held_o = out_q.turn_while_held;

  // A press event always replaces the step.
  a_press_clears_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.press_event != PRESS_NONE |-> out_q.turn_dir == TURN_NONE)
    else $error("press event reported together with a step");

  // The held-turn flag comes only with a step.
  a_flag_needs_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.turn_while_held |-> out_q.turn_dir != TURN_NONE)
    else $error("turn_while_held without a step");

  // The skid entry is only filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A running timer implies the button is debounced as pressed.
  a_timer_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_q != '0 |-> debounced_q)
    else $error("press timer running while released");

  // A stalled result is held until taken.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
